[rtl/tail_mass_drop_selector_top_assert.svh]
// Assertion macros for the tail mass drop selector.
`ifndef TAIL_MASS_DROP_SELECTOR_TOP_ASSERT_SVH
`define TAIL_MASS_DROP_SELECTOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define TMDS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tmds assertion failed");

// Next-cycle implication.
`define TMDS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tmds assertion failed");

`endif

[rtl/tmds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmds_pkg
// Shared types and constants of the tail mass drop selector.
// ----------------------------------------------------------------------------
package tmds_pkg;

  localparam int MaxTargets = 64;
  localparam int IdxW       = $clog2(MaxTargets);
  localparam int CntW       = IdxW + 1;
  localparam int ValW       = 32;
  localparam int KeyW       = 32;
  localparam int PctW       = 7;
  localparam int MassW      = 38;
  localparam int BudW       = MassW + PctW;

  localparam logic [CntW-1:0] MinFilter = CntW'(20);
  localparam logic [CntW-1:0] MinTail   = CntW'(2);
  localparam logic [PctW-1:0] FullPct   = PctW'(100);

  typedef struct packed {
    logic [ValW-1:0] val;
    logic [KeyW-1:0] key;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_BUDGET,
    S_SCAN,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_e;

endpackage

[rtl/tmds_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmds_ram
// Sorted target store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tmds_ram (
  input  logic              clk_i,
  input  tmds_pkg::ram_req_t req_i,
  output tmds_pkg::entry_t  rdata_o
);
  import tmds_pkg::*;

  entry_t mem [MaxTargets];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tail_mass_drop_selector_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tail_mass_drop_selector_top
// Keeps targets sorted by abundance then key, and on the last request marks
// the low tail whose mass fits the percent budget, then streams all out.
//
//   channel | signals                         | direction
//   in      | in_valid_i / in_ready_o         | request into block
//   out     | out_valid_o / out_ready_i       | result out of block
//   cfg     | cfg_we_i / cfg_wdata_i          | register write
//
// Insert: entries are shifted up one place at a time (up to 63), one memory port.
// A request taken while the store is full is dropped and sets the overflow flag.
// Last request: a budget step, a scan of up to 64 entries, then a read step
// and one result per entry for the stream, each held while out_ready_i is low.
// No request is taken while a run is scanned or streamed. No clearing pass.
// ----------------------------------------------------------------------------
module tail_mass_drop_selector_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tmds_pkg::PctW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tmds_pkg::KeyW-1:0]   target_key_i,
  input  logic [tmds_pkg::ValW-1:0]   abundance_i,
  input  logic                        last_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tmds_pkg::KeyW-1:0]   out_key_o,
  output logic [tmds_pkg::ValW-1:0]   out_abundance_o,
  output logic                        dropped_o,
  output logic                        overflowed_o,
  output logic                        last_result_o
);
  import tmds_pkg::*;

  state_e          state_q, state_d;
  logic [PctW-1:0] pct_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [MassW-1:0] total_q, total_d;
  logic            ovf_q, ovf_d;
  logic            last_q, last_d;
  entry_t          new_q, new_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] cut_q, cut_d;
  logic [MassW-1:0] acc_q, acc_d;
  logic [BudW-1:0] bud_q, bud_d;
  ram_req_t        req;
  entry_t          rdata;
  logic [PctW-1:0] pct_sat;
  logic            goes_first;
  logic [MassW-1:0] cand;
  logic            fits;
  logic [CntW-1:0] n_inc;
  logic            finish;

  tmds_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (req),
    .rdata_o(rdata)
  );

  assign pct_sat    = (pct_q > FullPct) ? FullPct : pct_q;
  assign goes_first = (new_q.val < rdata.val) ||
                      ((new_q.val == rdata.val) && (new_q.key < rdata.key));
  assign cand       = acc_q + MassW'(rdata.val);
  assign fits       = (BudW'(cand) * BudW'(FullPct)) <= bud_q;
  assign n_inc      = n_q + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q <= '0;
    end else if (cfg_we_i) begin
      pct_q <= cfg_wdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (cnt_q == CntW'(MaxTargets)) begin
            state_d = last_item_i ? S_BUDGET : S_IDLE;
          end else if (cnt_q == '0) begin
            state_d = S_PUT;
          end else begin
            state_d = S_INS;
          end
        end
      end
      S_INS: begin
        if (!goes_first) begin
          state_d = last_q ? S_BUDGET : S_IDLE;
        end else if (pos_q == CntW'(1)) begin
          state_d = S_PUT;
        end
      end
      S_PUT:    state_d = last_q ? S_BUDGET : S_IDLE;
      S_BUDGET: begin
        if (cnt_q == '0) begin
          state_d = S_IDLE;
        end else if (cnt_q >= MinFilter && total_q != '0 && pct_sat != '0) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_EMIT_RD;
        end
      end
      S_SCAN: begin
        if (!fits || n_inc == cnt_q) begin
          state_d = S_EMIT_RD;
        end
      end
      S_EMIT_RD:  state_d = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (out_ready_i && (n_inc == cnt_q)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_d   = cnt_q;
    total_d = total_q;
    ovf_d   = ovf_q;
    last_d  = last_q;
    new_d   = new_q;
    pos_d   = pos_q;
    n_d     = n_q;
    cut_d   = cut_q;
    acc_d   = acc_q;
    bud_d   = bud_q;
    finish  = 1'b0;
    req     = '0;
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = (state_q == S_EMIT_OUT);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          new_d.key = target_key_i;
          new_d.val = abundance_i;
          last_d    = last_item_i;
          pos_d     = cnt_q;
          if (cnt_q == CntW'(MaxTargets)) begin
            ovf_d = 1'b1;
          end else begin
            req.re    = 1'b1;
            req.raddr = IdxW'(cnt_q - CntW'(1));
          end
        end
      end
      S_INS: begin
        if (goes_first) begin
          req.we    = 1'b1;
          req.waddr = pos_q[IdxW-1:0];
          req.wdata = rdata;
          pos_d     = pos_q - CntW'(1);
          req.re    = 1'b1;
          req.raddr = IdxW'(pos_q - CntW'(2));
        end else begin
          req.we    = 1'b1;
          req.waddr = pos_q[IdxW-1:0];
          req.wdata = new_q;
          finish    = 1'b1;
        end
      end
      S_PUT: begin
        req.we    = 1'b1;
        req.waddr = pos_q[IdxW-1:0];
        req.wdata = new_q;
        finish    = 1'b1;
      end
      S_BUDGET: begin
        bud_d     = BudW'(pct_sat) * BudW'(total_q);
        n_d       = '0;
        acc_d     = '0;
        cut_d     = '0;
        req.re    = 1'b1;
        req.raddr = '0;
        if (cnt_q == '0) begin
          total_d = '0;
          ovf_d   = 1'b0;
        end
      end
      S_SCAN: begin
        if (fits) begin
          acc_d     = cand;
          n_d       = n_inc;
          req.re    = 1'b1;
          req.raddr = n_inc[IdxW-1:0];
        end
        if (!fits || n_inc == cnt_q) begin
          cut_d = (n_d >= MinTail && n_d < cnt_q) ? n_d : '0;
          n_d   = '0;
        end
      end
      S_EMIT_RD: begin
        req.re    = 1'b1;
        req.raddr = n_q[IdxW-1:0];
      end
      S_EMIT_OUT: begin
        if (out_ready_i) begin
          if (n_inc == cnt_q) begin
            cnt_d   = '0;
            total_d = '0;
            ovf_d   = 1'b0;
          end else begin
            n_d       = n_inc;
            req.re    = 1'b1;
            req.raddr = n_inc[IdxW-1:0];
          end
        end
      end
      default: ;
    endcase
    if (finish) begin
      cnt_d   = cnt_q + CntW'(1);
      total_d = total_q + MassW'(new_q.val);
    end
  end

  assign out_key_o       = rdata.key;
  assign out_abundance_o = rdata.val;
  assign dropped_o       = (n_q < cut_q);
  assign overflowed_o    = ovf_q;
  assign last_result_o   = (n_inc == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
      pos_q   <= '0;
      n_q     <= '0;
      cut_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
      pos_q   <= pos_d;
      n_q     <= n_d;
      cut_q   <= cut_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    acc_q <= acc_d;
    bud_q <= bud_d;
  end

  `include "tail_mass_drop_selector_top_assert.svh"

  `TMDS_ASSERT_IMP(a_out_blocks_in, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `TMDS_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(MaxTargets))
  `TMDS_ASSERT_IMP(a_scan_idx, clk_i, rst_ni, state_q == S_SCAN, n_q < cnt_q)
  `TMDS_ASSERT_NXT(a_run_clear, clk_i, rst_ni,
                   out_valid_o && out_ready_i && last_result_o, cnt_q == '0)

endmodule

[tb/sv/tail_mass_drop_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tail_mass_drop_checker
// Watches the request and result channels of the tail mass drop selector. It
// keeps its own sorted store and cutoff rule, computes the result stream for
// each run-ending request, and compares every result field by field.
// ----------------------------------------------------------------------------
module tail_mass_drop_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tmds_pkg::PctW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [tmds_pkg::KeyW-1:0]  target_key_i,
  input  logic [tmds_pkg::ValW-1:0]  abundance_i,
  input  logic                       last_item_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [tmds_pkg::KeyW-1:0]  out_key_i,
  input  logic [tmds_pkg::ValW-1:0]  out_abundance_i,
  input  logic                       dropped_i,
  input  logic                       overflowed_i,
  input  logic                       last_result_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import tmds_pkg::*;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] val;
    logic            drop;
    logic            ovf;
    logic            last;
  } sorted_row_t;

  logic [ValW-1:0]  store_val [MaxTargets];
  logic [KeyW-1:0]  store_key [MaxTargets];
  int               store_cnt;
  logic [MassW-1:0] mass_sum;
  logic             ovf_seen;
  logic [PctW-1:0]  drop_pct;
  sorted_row_t      rows_due[$];
  int               fails;

  assign fail_count_o = fails;
  assign pending_o    = rows_due.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  task automatic add_target(input logic [KeyW-1:0] k, input logic [ValW-1:0] v);
    int p;
    p = store_cnt;
    while (p > 0 && (v < store_val[p-1] || (v == store_val[p-1] && k < store_key[p-1])))
    begin
      store_val[p] = store_val[p-1];
      store_key[p] = store_key[p-1];
      p--;
    end
    store_val[p] = v;
    store_key[p] = k;
    store_cnt++;
    mass_sum += MassW'(v);
  endtask

  function automatic int tail_cut();
    logic [63:0] pct, budget, acc, cand;
    int n;
    pct = (drop_pct > FullPct) ? 64'd100 : 64'(drop_pct);
    if (store_cnt < 20 || mass_sum == 0 || pct == 0) return 0;
    budget = pct * 64'(mass_sum);
    acc = 0;
    n = 0;
    while (n < store_cnt) begin
      cand = acc + 64'(store_val[n]);
      if (cand * 100 > budget) break;
      acc = cand;
      n++;
    end
    if (n < 2 || n >= store_cnt) return 0;
    return n;
  endfunction

  task automatic close_run();
    int cut;
    sorted_row_t r;
    cut = tail_cut();
    for (int i = 0; i < store_cnt; i++) begin
      r.key  = store_key[i];
      r.val  = store_val[i];
      r.drop = i < cut;
      r.ovf  = ovf_seen;
      r.last = (i + 1 == store_cnt);
      rows_due = {rows_due, r};
    end
    store_cnt = 0;
    mass_sum  = '0;
    ovf_seen  = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_row_t e;
    if (!rst_ni) begin
      store_cnt = 0;
      mass_sum  = '0;
      ovf_seen  = 1'b0;
      drop_pct  = '0;
      fails     = 0;
      rows_due.delete();
    end else begin
      if (cfg_we_i) drop_pct = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (rows_due.size() == 0) begin
          report_mismatch("unexpected result", out_key_i, 0);
        end else begin
          e = rows_due.pop_front();
          if (out_key_i != e.key) report_mismatch("key", out_key_i, e.key);
          if (out_abundance_i != e.val) report_mismatch("abundance", out_abundance_i, e.val);
          if (dropped_i != e.drop) report_mismatch("dropped", dropped_i, e.drop);
          if (overflowed_i != e.ovf) report_mismatch("overflowed", overflowed_i, e.ovf);
          if (last_result_i != e.last) report_mismatch("last", last_result_i, e.last);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (store_cnt < MaxTargets) add_target(target_key_i, abundance_i);
        else ovf_seen = 1'b1;
        if (last_item_i) close_run();
      end
    end
  end

  final begin
    if (rows_due.size() != 0) $display("mismatch: %0d results missing", rows_due.size());
  end
endmodule

[tb/sv/tb_tail_mass_drop_selector_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tail_mass_drop_selector_top
// Drives runs of targets into the tail mass drop selector: small and full
// sets, overflowing sets, ties and extreme abundances, under
// several percent settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_tail_mass_drop_selector_top;
  import tmds_pkg::*;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [PctW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [KeyW-1:0] target_key_i = '0;
  logic [ValW-1:0] abundance_i = '0;
  logic            last_item_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [KeyW-1:0] out_key_o;
  logic [ValW-1:0] out_abundance_o;
  logic            dropped_o, overflowed_o, last_result_o;
  int              fail_count, pending, cycles;
  bit              calm;

  tail_mass_drop_selector_top dut (.*);

  tail_mass_drop_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i,
    .in_ready_i(in_ready_o), .target_key_i, .abundance_i, .last_item_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_key_i(out_key_o),
    .out_abundance_i(out_abundance_o), .dropped_i(dropped_o),
    .overflowed_i(overflowed_o), .last_result_i(last_result_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("tb_tail_mass_drop_selector_top: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 11);
  end

  // valid stays high after acceptance until the next send or drain updates it
  task automatic send_target(input logic [KeyW-1:0] k, input logic [ValW-1:0] v,
                             input logic lst);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    target_key_i <= k;
    abundance_i  <= v;
    last_item_i  <= lst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic set_pct(input logic [PctW-1:0] p);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= p;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_set(input int n, input int mode);
    logic [ValW-1:0] v;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: v = $urandom();
        1: v = $urandom_range(7);
        2: v = (i < n / 2) ? $urandom_range(1000) : 32'hF000_0000 | $urandom();
        default: v = 0;
      endcase
      send_target((mode == 1) ? $urandom_range(3) : $urandom(), v, i == n - 1);
    end
  endtask

  initial begin
    int sent;
    calm = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_target(0, 0, 1'b1);
    send_target(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_target(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_target(0, 32'hFFFF_FFFF, 1'b0);
    send_target(5, 0, 1'b1);
    set_pct(100);
    run_set(20, 2);
    set_pct(127);
    run_set(20, 1);
    set_pct(0);
    run_set(21, 0);
    set_pct(30);
    run_set(20, 3);
    calm = 1'b1;
    run_set(66, 2);
    drain();
    calm = 1'b0;
    sent = 0;
    while (sent < 10) begin
      int n;
      set_pct($urandom_range(100) | ($urandom_range(9) == 0 ? 7'h40 : 0));
      n = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(5, 12);
      run_set(n + 1, $urandom_range(3));
      sent += n + 1;
    end
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_tail_mass_drop_selector_top: PASS");
    end else begin
      $display("tb_tail_mass_drop_selector_top: FAIL");
    end
    $finish;
  end
endmodule
